### src/tlc_pkg.sv
// ----------------------------------------------------------------------------
// tlc_pkg
// Shared types, lamp codes and seven-segment codes of the traffic light
// controller.
// ----------------------------------------------------------------------------
package tlc_pkg;

    localparam int TICK_W  = 5;
    localparam int COUNT_W = 8;
    localparam int RELOAD_W = 7;
    localparam int SEG_W   = 8;

    localparam logic [1:0] CFG_MAIN_A = 2'd0;
    localparam logic [1:0] CFG_MAIN_B = 2'd1;
    localparam logic [1:0] CFG_SIDE_A = 2'd2;
    localparam logic [1:0] CFG_SIDE_B = 2'd3;

    localparam logic [5:0] L_AR = 6'h01;
    localparam logic [5:0] L_AY = 6'h02;
    localparam logic [5:0] L_AG = 6'h04;
    localparam logic [5:0] L_BR = 6'h08;
    localparam logic [5:0] L_BY = 6'h10;
    localparam logic [5:0] L_BG = 6'h20;

    localparam logic [5:0] LAMPS_RESET = L_AR | L_BG;
    localparam logic [5:0] LAMPS_SIDE  = L_AG | L_BR;
    localparam logic [5:0] LAMPS_EMERG = L_AY | L_BY;

    localparam logic [COUNT_W-1:0] COUNT_A_RESET = 8'd60;
    localparam logic [COUNT_W-1:0] COUNT_B_RESET = 8'd63;
    localparam logic [RELOAD_W-1:0] MAIN_A_RESET = 7'd60;
    localparam logic [RELOAD_W-1:0] MAIN_B_RESET = 7'd63;
    localparam logic [RELOAD_W-1:0] SIDE_A_RESET = 7'd33;
    localparam logic [RELOAD_W-1:0] SIDE_B_RESET = 7'd30;

    localparam logic [SEG_W-1:0] SEG_BLANK = 8'h00;
    localparam logic [SEG_W-1:0] SEG_F     = 8'h71;

    typedef struct packed {
        logic [RELOAD_W-1:0] main_a;
        logic [RELOAD_W-1:0] main_b;
        logic [RELOAD_W-1:0] side_a;
        logic [RELOAD_W-1:0] side_b;
    } t_reload;

    typedef struct packed {
        logic [5:0]         lamps;
        logic [COUNT_W-1:0] count_a;
        logic [COUNT_W-1:0] count_b;
        logic               emergency;
    } t_status;

    function automatic logic [SEG_W-1:0] digit_seg(input logic [3:0] d);
        logic [SEG_W-1:0] s;
        case (d)
            4'd0: s = 8'h3f;
            4'd1: s = 8'h06;
            4'd2: s = 8'h5b;
            4'd3: s = 8'h4f;
            4'd4: s = 8'h66;
            4'd5: s = 8'h6d;
            4'd6: s = 8'h7d;
            4'd7: s = 8'h07;
            4'd8: s = 8'h7f;
            4'd9: s = 8'h6f;
            default: s = SEG_BLANK;
        endcase
        return s;
    endfunction

endpackage

### src/tlc_seg.sv
// ----------------------------------------------------------------------------
// tlc_seg
// Splits one counter into tens and units and drives their seven-segment
// codes (tens blank from 100 up), or the F pattern during an emergency.
// ----------------------------------------------------------------------------
module tlc_seg (
    input  logic [tlc_pkg::COUNT_W-1:0] i_value,
    input  logic                        i_emergency,
    output logic [tlc_pkg::SEG_W-1:0]   o_tens,
    output logic [tlc_pkg::SEG_W-1:0]   o_units
);

    logic [15:0] product;
    logic [4:0]  tens;
    logic [7:0]  tens_x10;
    logic [7:0]  units;

    // Multiplying by 205/2048 gives the exact quotient by ten for 8-bit values.
    assign product  = 16'(i_value) * 16'd205;
    assign tens     = product[15:11];
    assign tens_x10 = 8'({3'd0, tens} * 8'd10);
    assign units    = i_value - tens_x10;

    always_comb begin
        if (i_emergency) begin
            o_tens  = tlc_pkg::SEG_F;
            o_units = tlc_pkg::SEG_F;
        end else begin
            o_tens  = (tens < 5'd10) ? tlc_pkg::digit_seg(tens[3:0]) : tlc_pkg::SEG_BLANK;
            o_units = tlc_pkg::digit_seg(units[3:0]);
        end
    end

endmodule

### src/tlc_core.sv
// ----------------------------------------------------------------------------
// tlc_core
// Holds the controller state and computes the lamp and counter update for
// one tick in a single pass.
// ----------------------------------------------------------------------------
module tlc_core #(
    parameter int TICKS_PER_SECOND = 20,
    parameter int FLASH_SECONDS    = 3
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_advance,
    input  logic             i_held,
    input  tlc_pkg::t_reload i_reload,
    output tlc_pkg::t_status o_status
);

    localparam logic [tlc_pkg::TICK_W-1:0]  TickSecond = tlc_pkg::TICK_W'(TICKS_PER_SECOND);
    localparam logic [tlc_pkg::TICK_W-1:0]  TickHalf   =
        tlc_pkg::TICK_W'(TICKS_PER_SECOND / 2);
    localparam logic [tlc_pkg::COUNT_W-1:0] FlashCount = tlc_pkg::COUNT_W'(FLASH_SECONDS);

    logic [tlc_pkg::TICK_W-1:0]  r_tick,   n_tick;
    logic [tlc_pkg::COUNT_W-1:0] r_cnt_a,  n_cnt_a;
    logic [tlc_pkg::COUNT_W-1:0] r_cnt_b,  n_cnt_b;
    logic                        r_side,   n_side;
    logic                        r_fgrp_a, n_fgrp_a;
    logic                        r_fen,    n_fen;
    logic                        r_recov,  n_recov;
    logic                        r_emerg,  n_emerg;
    logic [5:0]                  r_lamps,  n_lamps;

    always_comb begin
        n_tick   = r_tick + 1'b1;
        n_cnt_a  = r_cnt_a;
        n_cnt_b  = r_cnt_b;
        n_side   = r_side;
        n_fgrp_a = r_fgrp_a;
        n_fen    = r_fen;
        n_recov  = r_recov;
        n_emerg  = r_emerg;
        n_lamps  = r_lamps;
        if (!i_held) begin
            n_emerg = 1'b0;
            if (r_recov) begin
                n_lamps = tlc_pkg::LAMPS_RESET;
                n_recov = 1'b0;
                n_tick  = '0;
            end
            if (n_tick == TickHalf) begin
                if (r_fen && !r_fgrp_a && r_cnt_b <= FlashCount) begin
                    n_lamps = n_lamps & ~(tlc_pkg::L_BG | tlc_pkg::L_BY);
                end
                if (r_fen && r_fgrp_a && r_cnt_a <= FlashCount) begin
                    n_lamps = n_lamps & ~(tlc_pkg::L_AG | tlc_pkg::L_AY);
                end
            end
            if (n_tick == TickSecond) begin
                n_tick  = '0;
                n_cnt_a = r_cnt_a - 1'b1;
                n_cnt_b = r_cnt_b - 1'b1;
                if (r_fen && !r_fgrp_a && n_cnt_b <= FlashCount) begin
                    n_lamps = (n_lamps & ~tlc_pkg::L_BG) | tlc_pkg::L_BY;
                end
                if (r_fen && r_fgrp_a && n_cnt_a <= FlashCount) begin
                    n_lamps = (n_lamps & ~tlc_pkg::L_AG) | tlc_pkg::L_AY;
                end
                if (n_cnt_a == '0 && n_cnt_b == FlashCount) begin
                    n_cnt_a = FlashCount;
                    n_fen   = 1'b1;
                end
                if (n_cnt_a == FlashCount && n_cnt_b == '0) begin
                    n_cnt_b = FlashCount;
                    n_fen   = 1'b1;
                end
                if (n_cnt_a == '0 && n_cnt_b == '0) begin
                    n_fgrp_a = !r_fgrp_a;
                    n_fen    = 1'b0;
                    if (!r_side) begin
                        n_lamps = tlc_pkg::LAMPS_SIDE;
                        n_cnt_a = {1'b0, i_reload.side_a};
                        n_cnt_b = {1'b0, i_reload.side_b};
                    end else begin
                        n_lamps = tlc_pkg::LAMPS_RESET;
                        n_cnt_a = {1'b0, i_reload.main_a};
                        n_cnt_b = {1'b0, i_reload.main_b};
                    end
                    n_side = !r_side;
                end
            end
        end else begin
            n_emerg = 1'b1;
            n_side  = 1'b0;
            n_lamps = tlc_pkg::LAMPS_EMERG;
            n_cnt_a = {1'b0, i_reload.main_a};
            n_cnt_b = {1'b0, i_reload.main_b};
            n_tick  = '0;
            n_recov = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick   <= '0;
            r_cnt_a  <= tlc_pkg::COUNT_A_RESET;
            r_cnt_b  <= tlc_pkg::COUNT_B_RESET;
            r_side   <= 1'b0;
            r_fgrp_a <= 1'b0;
            r_fen    <= 1'b0;
            r_recov  <= 1'b0;
            r_emerg  <= 1'b0;
            r_lamps  <= tlc_pkg::LAMPS_RESET;
        end else if (i_advance) begin
            r_tick   <= n_tick;
            r_cnt_a  <= n_cnt_a;
            r_cnt_b  <= n_cnt_b;
            r_side   <= n_side;
            r_fgrp_a <= n_fgrp_a;
            r_fen    <= n_fen;
            r_recov  <= n_recov;
            r_emerg  <= n_emerg;
            r_lamps  <= n_lamps;
        end
    end

    assign o_status.lamps     = n_lamps;
    assign o_status.count_a   = n_cnt_a;
    assign o_status.count_b   = n_cnt_b;
    assign o_status.emergency = n_emerg;

endmodule

### src/two_way_traffic_light_controller.sv
// ----------------------------------------------------------------------------
// two_way_traffic_light_controller
// Two-group traffic light controller with countdown displays and an
// emergency override, advanced by one tick item at a time.
// ----------------------------------------------------------------------------
// Each input item is one timer tick and yields one result item holding the
// lamps and the four seven-segment digits after that tick. The block takes
// one item per clock cycle while its result is not stalled. An item is accepted
// into the input register, and once the result register is free the update
// stage writes the state and the result register, from which the result is
// on the outputs until it is taken. A stalled result holds the input
// register, and the input side stalls only while both registers are full.
module two_way_traffic_light_controller #(
    parameter int TICKS_PER_SECOND = 20,
    parameter int FLASH_SECONDS    = 3
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [1:0]                   i_cfg_index,
    input  logic [tlc_pkg::RELOAD_W-1:0] i_cfg_data,
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic                         i_emergency_held,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic                         o_a_red,
    output logic                         o_a_yellow,
    output logic                         o_a_green,
    output logic                         o_b_red,
    output logic                         o_b_yellow,
    output logic                         o_b_green,
    output logic [tlc_pkg::SEG_W-1:0]    o_seg_b_tens,
    output logic [tlc_pkg::SEG_W-1:0]    o_seg_b_units,
    output logic [tlc_pkg::SEG_W-1:0]    o_seg_a_tens,
    output logic [tlc_pkg::SEG_W-1:0]    o_seg_a_units,
    output logic                         o_emergency_shown
);

    tlc_pkg::t_reload r_reload;
    tlc_pkg::t_status next_status;
    tlc_pkg::t_status r_out;
    logic             r_in_valid;
    logic             r_in_held;
    logic             r_out_valid;
    logic             out_free;
    logic             advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_reload.main_a <= tlc_pkg::MAIN_A_RESET;
            r_reload.main_b <= tlc_pkg::MAIN_B_RESET;
            r_reload.side_a <= tlc_pkg::SIDE_A_RESET;
            r_reload.side_b <= tlc_pkg::SIDE_B_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                tlc_pkg::CFG_MAIN_A: r_reload.main_a <= i_cfg_data;
                tlc_pkg::CFG_MAIN_B: r_reload.main_b <= i_cfg_data;
                tlc_pkg::CFG_SIDE_A: r_reload.side_a <= i_cfg_data;
                tlc_pkg::CFG_SIDE_B: r_reload.side_b <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign out_free   = !r_out_valid || !i_out_stall;
    assign advance    = r_in_valid && out_free;
    assign o_in_stall = r_in_valid && !out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall && i_in_valid) begin
            r_in_held <= i_emergency_held;
        end
    end

    tlc_core #(
        .TICKS_PER_SECOND(TICKS_PER_SECOND),
        .FLASH_SECONDS   (FLASH_SECONDS)
    ) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_advance(advance),
        .i_held   (r_in_held),
        .i_reload (r_reload),
        .o_status (next_status)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= next_status;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_a_red           = |(r_out.lamps & tlc_pkg::L_AR);
    assign o_a_yellow        = |(r_out.lamps & tlc_pkg::L_AY);
    assign o_a_green         = |(r_out.lamps & tlc_pkg::L_AG);
    assign o_b_red           = |(r_out.lamps & tlc_pkg::L_BR);
    assign o_b_yellow        = |(r_out.lamps & tlc_pkg::L_BY);
    assign o_b_green         = |(r_out.lamps & tlc_pkg::L_BG);
    assign o_emergency_shown = r_out.emergency;

    tlc_seg u_seg_a (
        .i_value    (r_out.count_a),
        .i_emergency(r_out.emergency),
        .o_tens     (o_seg_a_tens),
        .o_units    (o_seg_a_units)
    );

    tlc_seg u_seg_b (
        .i_value    (r_out.count_b),
        .i_emergency(r_out.emergency),
        .o_tens     (o_seg_b_tens),
        .o_units    (o_seg_b_units)
    );

    a_emerg_lamps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.emergency) |-> (r_out.lamps == tlc_pkg::LAMPS_EMERG))
        else $error("emergency result without both yellow lamps");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_out_stall) |=> (r_out_valid && $stable(r_out)))
        else $error("stalled result item changed");

    a_advance_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance |=> r_out_valid)
        else $error("updated item did not reach the result register");

endmodule
